// ===== hdl/lmsc_pkg.sv =====
// Shared types and constants of the LED matrix shadow command generator.
`default_nettype none

package lmsc_pkg;

    localparam int NUM_ROWS = 8;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    localparam logic [3:0] OP_LED      = 4'd0;
    localparam logic [3:0] OP_ROW      = 4'd1;
    localparam logic [3:0] OP_COLUMN   = 4'd2;
    localparam logic [3:0] OP_CLEAR    = 4'd3;
    localparam logic [3:0] OP_PWRDN    = 4'd4;
    localparam logic [3:0] OP_SCAN     = 4'd5;
    localparam logic [3:0] OP_BRIGHT   = 4'd6;
    localparam logic [3:0] OP_DIGIT    = 4'd7;
    localparam logic [3:0] OP_TRANSMIT = 4'd8;

    localparam logic [3:0] REG_INTENSITY = 4'd10;
    localparam logic [3:0] REG_SCANLIMIT = 4'd11;
    localparam logic [3:0] REG_SHUTDOWN  = 4'd12;

    localparam logic [7:0] LEFT_COLUMN     = 8'h80;
    localparam logic [7:0] SCANLIMIT_LIMIT = 8'd8;
    localparam logic [7:0] INTENSITY_LIMIT = 8'd16;

    typedef logic [NUM_ROWS-1:0] t_row_mask;

    typedef struct packed {
        logic [3:0] opcode;
        logic [3:0] position;
        logic [7:0] value;
        logic       turn_on;
        logic       decimal_point;
        logic       defer_send;
        logic       changed_only;
    } t_in_req;

    typedef struct packed {
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       last_of_run;
    } t_out_req;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [ROW_W-1:0] addr;
        logic [7:0]       wdata;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_CTRL
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/lmsc_row_mem.sv =====
// Row shadow memory: synchronous read, one write port, per-row valid bits for reset-to-zero.
`default_nettype none

module lmsc_row_mem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lmsc_pkg::t_mem_req i_req,
    output logic [7:0]             o_rd_data
);

    logic [7:0]                r_mem [lmsc_pkg::NUM_ROWS];
    lmsc_pkg::t_row_mask       r_vld;
    logic [7:0]                r_rd_data;
    logic                      r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.addr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_vld <= r_vld[i_req.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

`default_nettype wire

// ===== hdl/led_matrix_shadow_command_gen.sv =====
// Top level: command decode, row read-modify-write sequencer and output word register.
//
//   channel  | valid   | ready   | payload
//   ---------+---------+---------+------------------------
//   command  | i_valid | o_ready | i_in  (t_in_req)
//   word     | o_valid | i_ready | o_out (t_out_req)
//
// A row command is accepted, then takes a read step and a modify/write/emit step per
// selected row, and a skip in the read state per unselected row below the last
// selected one; column, clear and full transmit select all rows.
// Shutdown, scan limit and intensity go through the control step; ignored commands stay idle.
// The single-port row memory sets the per-row pace. Reset clears the rows via valid bits.
// A stalled output word holds the sequencer in its modify or control step.
`default_nettype none

module led_matrix_shadow_command_gen (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire lmsc_pkg::t_in_req  i_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output lmsc_pkg::t_out_req      o_out
);

    lmsc_pkg::t_state     r_state, n_state;
    lmsc_pkg::t_in_req    r_cmd, n_cmd;
    lmsc_pkg::t_row_mask  r_sel, n_sel;
    lmsc_pkg::t_row_mask  r_pending, n_pending;
    logic [lmsc_pkg::ROW_W-1:0] r_row, n_row;
    lmsc_pkg::t_out_req   r_out, n_out;
    lmsc_pkg::t_out_req   r_ctrl, n_ctrl;
    logic                 r_out_valid, n_out_valid;

    lmsc_pkg::t_mem_req   mem_req;
    logic [7:0]           rd_data;

    logic                 accept;
    logic                 go_mem;
    logic                 go_ctrl;
    logic                 pos_ok;
    lmsc_pkg::t_row_mask  acc_sel;
    lmsc_pkg::t_out_req   acc_ctrl;
    lmsc_pkg::t_row_mask  higher;
    logic                 row_last;
    logic                 out_free;
    logic [7:0]           new_row;
    logic [7:0]           led_mask;
    logic [7:0]           col_mask;
    logic                 col_bit;
    logic [7:0]           pattern;
    logic                 emit;
    logic                 do_write;
    logic                 proceed;

    lmsc_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign o_ready  = (r_state == lmsc_pkg::S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    // command decode at acceptance
    always_comb begin
        pos_ok   = (i_in.position < 4'(lmsc_pkg::NUM_ROWS));
        go_mem   = 1'b0;
        go_ctrl  = 1'b0;
        acc_sel  = lmsc_pkg::t_row_mask'(1) << i_in.position[lmsc_pkg::ROW_W-1:0];
        acc_ctrl = '0;
        unique case (i_in.opcode)
            lmsc_pkg::OP_LED: begin
                go_mem = pos_ok && (i_in.value < 8'd8);
            end
            lmsc_pkg::OP_ROW, lmsc_pkg::OP_DIGIT: begin
                go_mem = pos_ok;
            end
            lmsc_pkg::OP_COLUMN: begin
                go_mem  = pos_ok;
                acc_sel = '1;
            end
            lmsc_pkg::OP_CLEAR: begin
                go_mem  = 1'b1;
                acc_sel = '1;
            end
            lmsc_pkg::OP_TRANSMIT: begin
                acc_sel = i_in.changed_only ? r_pending : '1;
                go_mem  = (acc_sel != '0);
            end
            lmsc_pkg::OP_PWRDN: begin
                go_ctrl              = 1'b1;
                acc_ctrl.reg_address = lmsc_pkg::REG_SHUTDOWN;
                acc_ctrl.reg_data    = {7'd0, !i_in.turn_on};
            end
            lmsc_pkg::OP_SCAN: begin
                go_ctrl              = (i_in.value < lmsc_pkg::SCANLIMIT_LIMIT);
                acc_ctrl.reg_address = lmsc_pkg::REG_SCANLIMIT;
                acc_ctrl.reg_data    = i_in.value;
            end
            lmsc_pkg::OP_BRIGHT: begin
                go_ctrl              = (i_in.value < lmsc_pkg::INTENSITY_LIMIT);
                acc_ctrl.reg_address = lmsc_pkg::REG_INTENSITY;
                acc_ctrl.reg_data    = i_in.value;
            end
            default: begin
                go_mem  = 1'b0;
                go_ctrl = 1'b0;
            end
        endcase
        acc_ctrl.last_of_run = 1'b1;
    end

    // row modify datapath
    always_comb begin
        for (int i = 0; i < lmsc_pkg::NUM_ROWS; i++) begin
            higher[i] = (i > int'(r_row));
        end
        row_last = ((r_sel & higher) == '0);
        led_mask = lmsc_pkg::LEFT_COLUMN >> r_cmd.value[2:0];
        col_mask = lmsc_pkg::LEFT_COLUMN >> r_cmd.position[2:0];
        col_bit  = r_cmd.value[3'd7 - 3'(r_row)];
        pattern  = r_cmd.value | (r_cmd.decimal_point ? lmsc_pkg::LEFT_COLUMN : 8'h00);
        new_row  = rd_data;
        emit     = 1'b1;
        do_write = 1'b1;
        unique case (r_cmd.opcode)
            lmsc_pkg::OP_LED: begin
                new_row = r_cmd.turn_on ? (rd_data | led_mask) : (rd_data & ~led_mask);
            end
            lmsc_pkg::OP_ROW: begin
                new_row = r_cmd.value;
            end
            lmsc_pkg::OP_COLUMN: begin
                new_row = col_bit ? (rd_data | col_mask) : (rd_data & ~col_mask);
            end
            lmsc_pkg::OP_CLEAR: begin
                new_row = 8'h00;
            end
            lmsc_pkg::OP_DIGIT: begin
                new_row  = pattern;
                do_write = (rd_data != pattern);
                emit     = do_write && !r_cmd.defer_send;
            end
            default: begin
                do_write = 1'b0;
            end
        endcase
        proceed = !emit || out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmsc_pkg::S_IDLE: begin
                if (accept && go_mem) begin
                    n_state = lmsc_pkg::S_READ;
                end else if (accept && go_ctrl) begin
                    n_state = lmsc_pkg::S_CTRL;
                end
            end
            lmsc_pkg::S_READ: begin
                if (r_sel[r_row]) begin
                    n_state = lmsc_pkg::S_MODIFY;
                end
            end
            lmsc_pkg::S_MODIFY: begin
                if (proceed) begin
                    n_state = row_last ? lmsc_pkg::S_IDLE : lmsc_pkg::S_READ;
                end
            end
            lmsc_pkg::S_CTRL: begin
                if (out_free) begin
                    n_state = lmsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lmsc_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and register updates
    always_comb begin
        n_cmd       = r_cmd;
        n_sel       = r_sel;
        n_row       = r_row;
        n_pending   = r_pending;
        n_ctrl      = r_ctrl;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        mem_req     = '0;
        mem_req.addr  = r_row;
        mem_req.wdata = new_row;
        unique case (r_state)
            lmsc_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_in;
                    n_sel  = acc_sel;
                    n_row  = '0;
                    n_ctrl = acc_ctrl;
                    if (go_mem && (i_in.opcode == lmsc_pkg::OP_TRANSMIT)) begin
                        n_pending = r_pending & ~acc_sel;
                    end
                end
            end
            lmsc_pkg::S_READ: begin
                if (r_sel[r_row]) begin
                    mem_req.re = 1'b1;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            lmsc_pkg::S_MODIFY: begin
                if (proceed) begin
                    mem_req.we = do_write;
                    n_row      = r_row + 1'b1;
                    if (emit) begin
                        n_out.reg_address = 4'(r_row) + 4'd1;
                        n_out.reg_data    = new_row;
                        n_out.last_of_run = row_last;
                        n_out_valid       = 1'b1;
                    end
                    if (do_write && r_cmd.defer_send
                            && (r_cmd.opcode == lmsc_pkg::OP_DIGIT)) begin
                        n_pending[r_row] = 1'b1;
                    end
                end
            end
            lmsc_pkg::S_CTRL: begin
                if (out_free) begin
                    n_out       = r_ctrl;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmsc_pkg::S_IDLE;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_sel  <= n_sel;
        r_row  <= n_row;
        r_ctrl <= n_ctrl;
        r_out  <= n_out;
    end

    a_write_in_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_state == lmsc_pkg::S_MODIFY))
        else $error("row write outside modify step");

    a_read_then_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.re |=> (r_state == lmsc_pkg::S_MODIFY))
        else $error("row read not followed by modify step");

    a_transmit_all_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.opcode == lmsc_pkg::OP_TRANSMIT) && !i_in.changed_only)
        |=> (r_pending == '0))
        else $error("full transmit left pending rows");

    a_run_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_of_run) |-> (r_state != lmsc_pkg::S_IDLE))
        else $error("idle while a run of words is unfinished");

endmodule

`default_nettype wire
